// ----- src/hde_pkg.sv -----
// Shared types and constants for the hash difficulty estimator.
`default_nettype none
package hde_pkg;

  // Difficulty-1 target, top aligned to hash byte 29.
  localparam logic [63:0] BaseTop     = 64'hFFFF_0000_0000_0000;
  localparam logic [4:0]  BaseMsbByte = 5'd29;

  // Divisor has its top byte nonzero unless zero_res is set, so the quotient fits in one byte.
  localparam int QuotWidth = 8;

  typedef struct packed {
    logic [63:0] divisor;   // eight bytes from the top byte down
    logic [4:0]  shift;     // bytes the top byte lies below byte 29
    logic        zero_res;  // hash zero or above base: result is 0
  } item_t;

  typedef struct packed {
    logic [63:0]          rem;
    logic [QuotWidth-1:0] quo;
    item_t                itm;
  } stage_t;

endpackage
`default_nettype wire

// ----- src/hash_difficulty_estimate.sv -----
// Top level of the hash difficulty estimator.
// Scores one 256-bit hash per clock cycle when nothing stalls. From input
// transfer to result a hash passes one front register that finds the top
// byte and gathers the divisor, the queue, eight divider stages that each
// resolve one quotient bit, and the output register. The output register
// holds a finished result while the output stalls. The queue (QueueDepth
// entries) lets the front end keep taking hashes for a while when the
// output stalls.
`default_nettype none
module hash_difficulty_estimate #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] hash_word_0_i,
  input  wire logic [63:0] hash_word_1_i,
  input  wire logic [63:0] hash_word_2_i,
  input  wire logic [63:0] hash_word_3_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      difficulty_o,
  output logic             saturated_o
);

  logic           push_valid, push_full, pop_valid, pop_ready;
  hde_pkg::item_t push_item, pop_item;

  hde_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .hash_word_0_i,
    .hash_word_1_i,
    .hash_word_2_i,
    .hash_word_3_i,
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_full_i  (push_full)
  );

  hde_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .full_o       (push_full),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  hde_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .out_valid_o,
    .out_stall_i,
    .difficulty_o,
    .saturated_o
  );

endmodule
`default_nettype wire

// ----- src/hde_front.sv -----
// Front end: finds the top byte, classifies the hash and gathers the divisor.
`default_nettype none
module hde_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [63:0]   hash_word_0_i,
  input  wire logic [63:0]   hash_word_1_i,
  input  wire logic [63:0]   hash_word_2_i,
  input  wire logic [63:0]   hash_word_3_i,
  output logic               push_valid_o,
  output hde_pkg::item_t     push_item_o,
  input  wire logic          push_full_i
);

  logic [255:0]   hash;
  logic [319:0]   padded;
  logic [31:0]    byte_nz;
  logic [4:0]     top;
  logic [8:0]     base;
  logic           load;
  logic           valid_q;
  hde_pkg::item_t item_d, item_q;

  assign hash   = {hash_word_3_i, hash_word_2_i, hash_word_1_i, hash_word_0_i};
  // 64 zero bits below byte 0 cover a top byte under byte 7
  assign padded = {hash, 64'd0};

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      byte_nz[b] = |hash[b*8 +: 8];
    end
  end

  // highest nonzero byte among bytes 0..29; later hits win
  always_comb begin
    top = '0;
    for (int b = 0; b < 30; b++) begin
      if (byte_nz[b]) begin
        top = 5'(b);
      end
    end
  end

  assign base = {({1'b0, top} + 6'd1), 3'b000};

  always_comb begin
    item_d.divisor  = padded[base +: 64];
    item_d.shift    = hde_pkg::BaseMsbByte - top;
    item_d.zero_res = ~(|byte_nz[29:0]) | byte_nz[30] | byte_nz[31];
  end

  assign load         = !valid_q || !push_full_i;
  assign in_stall_o   = !load;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/hde_queue.sv -----
// Small FIFO between the front end and the divider pipeline.
`default_nettype none
module hde_queue #(
  parameter int Depth = 2  // 2 or more
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  input  hde_pkg::item_t     push_item_i,
  output logic               full_o,
  output logic               pop_valid_o,
  output hde_pkg::item_t     pop_item_o,
  input  wire logic          pop_ready_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  hde_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic push, pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/hde_back.sv -----
// Back end: pipelined restoring divider, byte scaling and output register.
`default_nettype none
module hde_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  hde_pkg::item_t     item_i,
  output logic               item_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [63:0]        difficulty_o,
  output logic               saturated_o
);

  localparam int Steps = hde_pkg::QuotWidth;

  hde_pkg::stage_t st [Steps+1];
  logic            vld [Steps+1];
  logic            rdy [Steps+2];

  logic            out_valid_q;
  logic [63:0]     diff_q, diff_d;
  logic            sat_q, sat_d;
  logic [Steps-1:0] quo;
  logic [4:0]      shift;

  // stage 0 is the queue head
  assign st[0]        = '{rem: hde_pkg::BaseTop, quo: '0, itm: item_i};
  assign vld[0]       = item_valid_i;
  assign item_ready_o = rdy[1];

  assign rdy[Steps+1] = !out_valid_q || !out_stall_i;

  for (genvar j = 1; j <= Steps; j++) begin : g_step
    localparam int Bit = Steps - j;
    logic [71:0]     rem_x, div_x, diff_x;
    logic            ge;
    hde_pkg::stage_t nxt;
    hde_pkg::stage_t st_q;
    logic            vld_q;

    assign rdy[j]  = !vld[j] || rdy[j+1];
    assign rem_x   = {8'd0, st[j-1].rem};
    assign div_x   = {8'd0, st[j-1].itm.divisor} << Bit;
    assign ge      = rem_x >= div_x;
    assign diff_x  = rem_x - div_x;

    always_comb begin
      nxt          = st[j-1];
      nxt.quo[Bit] = ge;
      if (ge) begin
        nxt.rem = diff_x[63:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (rdy[j]) begin
        vld_q <= vld[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && vld[j-1]) begin
        st_q <= nxt;
      end
    end

    assign vld[j] = vld_q;
    assign st[j]  = st_q;
  end

  // quotient is at most one byte: any scaling by eight or more bytes overflows
  assign quo   = st[Steps].quo;
  assign shift = st[Steps].itm.shift;

  always_comb begin
    if (st[Steps].itm.zero_res) begin
      diff_d = '0;
      sat_d  = 1'b0;
    end else if ((quo != '0) && (shift >= 5'd8)) begin
      diff_d = '1;
      sat_d  = 1'b1;
    end else begin
      diff_d = {56'd0, quo} << {shift[2:0], 3'b000};
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[Steps+1]) begin
      out_valid_q <= vld[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Steps+1] && vld[Steps]) begin
      diff_q <= diff_d;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign difficulty_o = diff_q;
  assign saturated_o  = sat_q;

endmodule
`default_nettype wire

// ----- src/hde_checker.sv -----
// Port-level checks for the hash difficulty estimator, bound to the top level.
`default_nettype none
module hde_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] difficulty_o,
  input wire logic        saturated_o
);

  logic [7:0] byte_nz;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_nz[b] = |difficulty_o[b*8 +: 8];
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(difficulty_o) && $stable(saturated_o))
    else $error("result changed during stall");

  // all ones appears exactly when the scaling saturated
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (saturated_o == (difficulty_o == '1)))
    else $error("saturation flag and value disagree");

  // an unsaturated result is a one-byte quotient moved up by whole bytes
  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !saturated_o |-> $onehot0(byte_nz))
    else $error("unsaturated result spans more than one byte");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

endmodule

bind hash_difficulty_estimate hde_checker u_hde_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .difficulty_o (difficulty_o),
  .saturated_o  (saturated_o)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the hash difficulty estimator.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } hash_t;

  typedef struct packed {
    logic [63:0] difficulty;
    logic        saturated;
  } score_t;

  localparam int TopByteLimit = int'(hde_pkg::BaseMsbByte);
  localparam int IdleLimit    = 2000;
  localparam int RandomHashes = 1200;
  localparam int TailCycles   = 20;

  // Byte fill below the top byte
  localparam int FillRandom = 0;
  localparam int FillZero   = 1;
  localparam int FillOnes   = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] hash_word_0_i = '0;
  logic [63:0] hash_word_1_i = '0;
  logic [63:0] hash_word_2_i = '0;
  logic [63:0] hash_word_3_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] difficulty_o;
  logic        saturated_o;

  hash_difficulty_estimate dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hash_word_0_i(hash_word_0_i),
    .hash_word_1_i(hash_word_1_i),
    .hash_word_2_i(hash_word_2_i),
    .hash_word_3_i(hash_word_3_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .difficulty_o (difficulty_o),
    .saturated_o  (saturated_o)
  );

  hash_t  hashes_to_send[$];
  score_t scores_expected[$];

  bit hash_presented = 1'b0;
  int send_gap       = 0;
  int recv_hold      = 0;
  int hashes_sent    = 0;
  int scores_checked = 0;
  int saturated_seen = 0;
  int zero_seen      = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected difficulty of one hash: top byte search, eight-byte divisor,
  // quotient scaled by 256 per byte below the base position, saturating.
  function automatic score_t score_hash(input hash_t h);
    logic [255:0] bits;
    logic [63:0]  divisor;
    logic [63:0]  quot;
    logic [7:0]   b;
    int           top;
    score_t       res;
    bits = h;
    top = -1;
    divisor = '0;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      if (top < 0 && bits[8*i +: 8] != 8'h00) top = i;
    end
    if (top < 0 || top > TopByteLimit) return res;
    for (int k = 0; k < 8; k++) begin
      b = (top - k >= 0) ? bits[8*(top-k) +: 8] : 8'h00;
      divisor = {divisor[55:0], b};
    end
    quot = hde_pkg::BaseTop / divisor;
    for (int s = 0; s < TopByteLimit - top; s++) begin
      if (quot[63:56] != 8'h00) begin
        quot = '1;
        res.saturated = 1'b1;
        break;
      end
      quot = quot << 8;
    end
    res.difficulty = quot;
    return res;
  endfunction

  // Hash whose most significant nonzero byte is top (-1 gives zero).
  // top_val of zero picks a random nonzero top byte.
  function automatic hash_t hash_with_top(input int top, input logic [7:0] top_val,
                                          input int fill);
    logic [255:0] bits;
    logic [7:0]   v;
    bits = '0;
    for (int i = 0; i < 32; i++) begin
      if (i == top) begin
        v = top_val;
        if (v == 8'h00) begin
          case ($urandom_range(0, 3))
            0: v = 8'h01;
            1: v = 8'hFF;
            default: v = 8'($urandom_range(1, 255));
          endcase
        end
        bits[8*i +: 8] = v;
      end else if (i < top) begin
        case (fill)
          FillZero: bits[8*i +: 8] = 8'h00;
          FillOnes: bits[8*i +: 8] = 8'hFF;
          default:  bits[8*i +: 8] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    return hash_t'(bits);
  endfunction

  function automatic int draw_wait(input bit no_idle);
    return no_idle ? 0 : int'($urandom_range(0, 11));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Input driver: payload changes on the falling edge, held while stalled
  always @(negedge clk_i) begin
    if (rst_ni && !hash_presented) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (hashes_to_send.size() != 0) begin
        hash_t h;
        h = hashes_to_send.pop_front();
        hash_word_0_i <= h.w0;
        hash_word_1_i <= h.w1;
        hash_word_2_i <= h.w2;
        hash_word_3_i <= h.w3;
        in_valid_i <= 1'b1;
        hash_presented = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: transfers on both channels, checking and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      bit any_transfer;
      score_t exp_score;
      any_transfer = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        any_transfer = 1'b1;
        if (scores_expected.size() == 0) begin
          report_mismatch($sformatf("result with no hash outstanding: difficulty %h sat %b",
                                    difficulty_o, saturated_o));
        end else begin
          exp_score = scores_expected.pop_front();
          if (difficulty_o !== exp_score.difficulty)
            report_mismatch($sformatf("result %0d difficulty %h, want %h", scores_checked,
                                      difficulty_o, exp_score.difficulty));
          if (saturated_o !== exp_score.saturated)
            report_mismatch($sformatf("result %0d saturated %b, want %b", scores_checked,
                                      saturated_o, exp_score.saturated));
        end
        if (saturated_o === 1'b1) saturated_seen++;
        if (difficulty_o === '0) zero_seen++;
        scores_checked++;
        recv_hold = draw_wait(((scores_checked / 100) % 4) >= 2);
      end
      if (in_valid_i && !in_stall_o) begin
        any_transfer = 1'b1;
        scores_expected.push_back(score_hash({hash_word_3_i, hash_word_2_i,
                                              hash_word_1_i, hash_word_0_i}));
        hashes_sent++;
        hash_presented = 1'b0;
        send_gap = draw_wait(((hashes_sent / 100) % 2) == 1);
      end
      idle_cycles = any_transfer ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
                 IdleLimit, scores_expected.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int top;
    int fill;
    // directed: zero, above base, base boundary, scaling edges, short tail
    hashes_to_send.push_back(hash_with_top(-1, 8'h00, FillZero));
    hashes_to_send.push_back(hash_with_top(31, 8'hFF, FillOnes));
    hashes_to_send.push_back(hash_t'({4{64'h5555_5555_5555_5555}}));
    hashes_to_send.push_back(hash_t'({4{64'hAAAA_AAAA_AAAA_AAAA}}));
    hashes_to_send.push_back(hash_with_top(31, 8'h01, FillZero));
    hashes_to_send.push_back(hash_with_top(30, 8'h00, FillRandom));
    hashes_to_send.push_back(hash_with_top(29, 8'h01, FillZero));
    hashes_to_send.push_back(hash_with_top(29, 8'hFF, FillOnes));
    hashes_to_send.push_back(hash_with_top(29, 8'h80, FillRandom));
    hashes_to_send.push_back(hash_with_top(28, 8'h00, FillRandom));
    hashes_to_send.push_back(hash_with_top(22, 8'h01, FillZero));
    hashes_to_send.push_back(hash_with_top(21, 8'hFF, FillZero));
    hashes_to_send.push_back(hash_with_top(21, 8'hFF, FillOnes));
    hashes_to_send.push_back(hash_with_top(21, 8'h01, FillRandom));
    hashes_to_send.push_back(hash_with_top(-1, 8'h00, FillZero));
    hashes_to_send.push_back(hash_with_top(7, 8'h00, FillRandom));
    hashes_to_send.push_back(hash_with_top(6, 8'h00, FillRandom));
    hashes_to_send.push_back(hash_with_top(2, 8'hFF, FillOnes));
    hashes_to_send.push_back(hash_with_top(0, 8'h01, FillZero));
    hashes_to_send.push_back(hash_with_top(0, 8'hFF, FillZero));
    for (int n = 0; n < RandomHashes; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        hashes_to_send.push_back(hash_t'({$urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom}));
      end else if (r < 12) begin
        top = (r == 8) ? -1 : int'($urandom_range(30, 31));
        hashes_to_send.push_back(hash_with_top(top, 8'h00, FillRandom));
      end else begin
        top = $urandom_range(0, TopByteLimit);
        case ($urandom_range(0, 5))
          0: fill = FillZero;
          1: fill = FillOnes;
          default: fill = FillRandom;
        endcase
        hashes_to_send.push_back(hash_with_top(top, 8'h00, fill));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (hashes_to_send.size() != 0 || hash_presented || scores_expected.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("scored %0d hashes, checked %0d results (%0d saturated, %0d zero)",
             hashes_sent, scores_checked, saturated_seen, zero_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/hde_pkg.sv
src/hde_front.sv
src/hde_queue.sv
src/hde_back.sv
src/hash_difficulty_estimate.sv
src/hde_checker.sv
tb/sv/testbench.sv
